[rtl/i2c_master_byte_engine_unit_macros.svh]
// Assertion macros shared by the I2C byte engine checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, skipped while reset is held
`define I2CMBE_AST_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, skipped while reset is held
`define I2CMBE_AST_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/i2cmbe_pkg.sv]
// Shared types and constants for the I2C master byte engine.
// No dependencies.
package i2cmbe_pkg;

    localparam int OP_W        = 2;
    localparam int HOLD_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PHASE_IDX_W = 5;

    // bus commands
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_GAP    = 2'd1;

    localparam logic [HOLD_W-1:0] HALF_PERIOD_RST = 16'd250;
    localparam logic [HOLD_W-1:0] READ_GAP_RST    = 16'd10000;

    // phase slots of note
    localparam logic [PHASE_IDX_W-1:0] IDX_FIRST    = 5'd0;
    localparam logic [PHASE_IDX_W-1:0] IDX_BITS_END = 5'd16;
    localparam logic [PHASE_IDX_W-1:0] IDX_WR_PRE   = 5'd17;
    localparam logic [PHASE_IDX_W-1:0] IDX_WR_ACK   = 5'd18;

    typedef enum logic [1:0] {
        HOLD_ZERO = 2'd0,
        HOLD_HALF = 2'd1,
        HOLD_GAP  = 2'd2
    } t_hold_sel;

    typedef struct packed {
        logic      scl;
        logic      sda;
        logic      drv;
        t_hold_sel hold_sel;
        logic      rotate;    // advance the shift register after this phase
        logic      rx_flag;   // show the received byte
        logic      ack_flag;  // show the write acknowledge result
        logic      last;
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

[rtl/i2cmbe_phase_gen.sv]
// Phase decoder: maps command and phase slot to line levels and flags.
// Depends on i2cmbe_pkg.
module i2cmbe_phase_gen (
    input  logic [i2cmbe_pkg::OP_W-1:0]        i_op,
    input  logic [i2cmbe_pkg::PHASE_IDX_W-1:0] i_idx,
    input  logic                               i_bit_msb,
    input  logic                               i_send_ack,
    input  logic                               i_sda_now,
    input  logic                               i_drv_now,
    output i2cmbe_pkg::t_phase                 o_phase
);

    always_comb begin
        o_phase          = '0;
        o_phase.hold_sel = i2cmbe_pkg::HOLD_ZERO;
        unique case (i_op)
            i2cmbe_pkg::OP_START: begin
                o_phase.scl = 1'b1;
                o_phase.drv = 1'b1;
                if (i_idx == i2cmbe_pkg::IDX_FIRST) begin
                    o_phase.sda      = 1'b1;
                    o_phase.hold_sel = i2cmbe_pkg::HOLD_HALF;
                end else begin
                    o_phase.last = 1'b1;
                end
            end
            i2cmbe_pkg::OP_STOP: begin
                o_phase.scl = 1'b1;
                o_phase.drv = 1'b1;
                if (i_idx == i2cmbe_pkg::IDX_FIRST) begin
                    o_phase.hold_sel = i2cmbe_pkg::HOLD_HALF;
                end else begin
                    o_phase.sda  = 1'b1;
                    o_phase.last = 1'b1;
                end
            end
            i2cmbe_pkg::OP_WRITE: begin
                if (i_idx == i2cmbe_pkg::IDX_FIRST) begin
                    o_phase.sda = i_sda_now;
                    o_phase.drv = i_drv_now;
                end else if (i_idx <= i2cmbe_pkg::IDX_BITS_END) begin
                    // odd slots clock high, even slots clock low
                    o_phase.scl      = i_idx[0];
                    o_phase.sda      = i_bit_msb;
                    o_phase.drv      = i_drv_now;
                    o_phase.hold_sel = i2cmbe_pkg::HOLD_HALF;
                    o_phase.rotate   = ~i_idx[0];
                end else if (i_idx == i2cmbe_pkg::IDX_WR_PRE) begin
                    o_phase.drv = 1'b1;
                end else if (i_idx == i2cmbe_pkg::IDX_WR_ACK) begin
                    o_phase.scl      = 1'b1;
                    o_phase.hold_sel = i2cmbe_pkg::HOLD_HALF;
                end else begin
                    o_phase.drv      = 1'b1;
                    o_phase.ack_flag = 1'b1;
                    o_phase.last     = 1'b1;
                end
            end
            i2cmbe_pkg::OP_READ: begin
                if (i_idx < i2cmbe_pkg::IDX_BITS_END) begin
                    o_phase.scl      = ~i_idx[0];
                    o_phase.sda      = i_sda_now;
                    o_phase.hold_sel = i2cmbe_pkg::HOLD_HALF;
                    o_phase.rotate   = i_idx[0];
                end else if (i_idx == i2cmbe_pkg::IDX_BITS_END && i_send_ack) begin
                    o_phase.scl      = 1'b1;
                    o_phase.drv      = 1'b1;
                    o_phase.hold_sel = i2cmbe_pkg::HOLD_HALF;
                end else begin
                    o_phase.sda      = i_sda_now;
                    o_phase.drv      = i_drv_now;
                    o_phase.hold_sel = i2cmbe_pkg::HOLD_GAP;
                    o_phase.rx_flag  = 1'b1;
                    o_phase.last     = 1'b1;
                end
            end
            default: o_phase = '0;
        endcase
    end

endmodule

[rtl/i2c_master_byte_engine_unit.sv]
// Top level of the I2C master byte engine.
// Depends on i2cmbe_pkg and i2cmbe_phase_gen.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) takes one bus command per word:
//    start, stop, write byte or read byte, plus the slave's response levels.
//  - Output channel (o_out_valid / i_out_ready) gives one word per line
//    phase: SCL level, SDA level, SDA drive enable and hold count. The final
//    phase of a command has o_last_phase set and carries rx_byte (read) or
//    ack_ok (write); both read zero on every other phase.
//  - Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//    half_period (index 0) or read_gap (index 1); other indexes are ignored.
// Sequence: a command emits 2 phases (start/stop), 17 or 18 (read) or 20
// (write). Once it is accepted, each phase is registered into the output
// word register whenever that register is free or being drained. The phase
// sequencer with its one 8-bit rotate register takes no new command while
// it runs; o_in_ready is high only while the sequencer is idle.
// A stall on i_out_ready freezes the sequencer; the pending word holds.
// Reset (synchronous, active low) returns to idle with the carried SDA state
// high and driven, half_period = 250, read_gap = 10000, and no word pending.
module i2c_master_byte_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [i2cmbe_pkg::OP_W-1:0]        i_op,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]      i_tx_byte,
    input  logic                               i_send_ack,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]      i_slave_bits,
    input  logic                               i_slave_sda_at_ack,
    // phase output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_scl_level,
    output logic                               o_sda_level,
    output logic                               o_sda_drive,
    output logic [i2cmbe_pkg::HOLD_W-1:0]      o_hold_cycles,
    output logic [i2cmbe_pkg::BYTE_W-1:0]      o_rx_byte,
    output logic                               o_ack_ok,
    output logic                               o_last_phase,
    // config write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    i2cmbe_pkg::t_state r_state, n_state;

    // config registers
    logic [i2cmbe_pkg::HOLD_W-1:0] r_half_period;
    logic [i2cmbe_pkg::HOLD_W-1:0] r_read_gap;

    // latched command
    logic [i2cmbe_pkg::OP_W-1:0]   r_op;
    logic                          r_send_ack;
    logic                          r_sack;
    logic [i2cmbe_pkg::BYTE_W-1:0] r_shift;   // tx byte or slave bits, rotated per bit

    // sequencer
    logic [i2cmbe_pkg::PHASE_IDX_W-1:0] r_idx;

    // SDA line state carried across commands
    logic r_sda, r_drv;

    // output word register
    logic                          r_out_valid;
    logic                          r_o_scl, r_o_sda, r_o_drv;
    logic [i2cmbe_pkg::HOLD_W-1:0] r_o_hold;
    logic [i2cmbe_pkg::BYTE_W-1:0] r_o_rx;
    logic                          r_o_ack;
    logic                          r_o_last;

    i2cmbe_pkg::t_phase            w_phase;
    logic                          w_accept;
    logic                          w_emit;
    logic [i2cmbe_pkg::HOLD_W-1:0] w_hold;

    i2cmbe_phase_gen u_phase_gen (
        .i_op       (r_op),
        .i_idx      (r_idx),
        .i_bit_msb  (r_shift[i2cmbe_pkg::BYTE_W-1]),
        .i_send_ack (r_send_ack),
        .i_sda_now  (r_sda),
        .i_drv_now  (r_drv),
        .o_phase    (w_phase)
    );

    assign o_in_ready  = (r_state == i2cmbe_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    // in ST_RUN, emit a phase whenever the output register is free or being drained
    assign w_emit      = (r_state == i2cmbe_pkg::ST_RUN) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (w_phase.hold_sel)
            i2cmbe_pkg::HOLD_HALF: w_hold = r_half_period;
            i2cmbe_pkg::HOLD_GAP:  w_hold = r_read_gap;
            default:               w_hold = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2cmbe_pkg::ST_IDLE: if (w_accept) begin
                n_state = i2cmbe_pkg::ST_RUN;
            end
            i2cmbe_pkg::ST_RUN: if (w_emit && w_phase.last) begin
                n_state = i2cmbe_pkg::ST_IDLE;
            end
            default: n_state = i2cmbe_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= i2cmbe_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_sda         <= 1'b1;
            r_drv         <= 1'b1;
            r_half_period <= i2cmbe_pkg::HALF_PERIOD_RST;
            r_read_gap    <= i2cmbe_pkg::READ_GAP_RST;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_sda       <= w_phase.sda;
                r_drv       <= w_phase.drv;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    i2cmbe_pkg::CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                    i2cmbe_pkg::CFG_READ_GAP:    r_read_gap    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // command latch, sequencer index and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_op;
            r_send_ack <= i_send_ack;
            r_sack     <= i_slave_sda_at_ack;
            r_shift    <= (i_op == i2cmbe_pkg::OP_READ) ? i_slave_bits : i_tx_byte;
            r_idx      <= i2cmbe_pkg::IDX_FIRST;
        end else if (w_emit) begin
            r_idx <= r_idx + 1'b1;
            if (w_phase.rotate) begin
                // rotate: write sends MSB each bit, read ends back at the full byte
                r_shift <= {r_shift[i2cmbe_pkg::BYTE_W-2:0], r_shift[i2cmbe_pkg::BYTE_W-1]};
            end
        end
        if (w_emit) begin
            r_o_scl  <= w_phase.scl;
            r_o_sda  <= w_phase.sda;
            r_o_drv  <= w_phase.drv;
            r_o_hold <= w_hold;
            r_o_rx   <= w_phase.rx_flag ? r_shift : '0;
            r_o_ack  <= w_phase.ack_flag & ~r_sack;
            r_o_last <= w_phase.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_o_scl;
    assign o_sda_level   = r_o_sda;
    assign o_sda_drive   = r_o_drv;
    assign o_hold_cycles = r_o_hold;
    assign o_rx_byte     = r_o_rx;
    assign o_ack_ok      = r_o_ack;
    assign o_last_phase  = r_o_last;

endmodule

[rtl/i2cmbe_checker.sv]
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on i2c_master_byte_engine_unit_macros.svh and i2cmbe_pkg.
`include "i2c_master_byte_engine_unit_macros.svh"

module i2cmbe_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_sda_drive,
    input logic [i2cmbe_pkg::HOLD_W-1:0]      o_hold_cycles,
    input logic [i2cmbe_pkg::BYTE_W-1:0]      o_rx_byte,
    input logic                               o_ack_ok,
    input logic                               o_last_phase
);

    // result fields only show on the final phase
    `I2CMBE_AST_NOW(a_ack_on_last, o_out_valid && o_ack_ok, o_last_phase)
    `I2CMBE_AST_NOW(a_rx_on_last, o_out_valid && (o_rx_byte != '0), o_last_phase)

    // a taken command makes the engine busy and drops o_in_ready
    `I2CMBE_AST_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled word holds
    `I2CMBE_AST_NXT(a_stall_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_hold_cycles) && $stable(o_sda_drive))

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_i2cmbe_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the I2C master byte engine.
// Depends on i2cmbe_pkg and the RTL top level i2c_master_byte_engine_unit.
`timescale 1ns / 100ps

module testbench;
    import i2cmbe_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 7;
    localparam int STALL_LIMIT  = 3000;  // cycles without any word moving
    localparam int SETTLE       = 4;     // wait in wait_idle after the last expected phase word
    localparam int TAIL_CYCLES  = 20;
    localparam int RAND_PER_SET = 25;

    // indexes the engine has no register for; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // one line phase as seen on the output channel
    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              drv;
        logic [HOLD_W-1:0] hold;
        logic [BYTE_W-1:0] rx;
        logic              ack;
        logic              last;
    } t_bus_phase;

    // Scoreboard: tracks the line state and config, expands each command
    // into its phase words, and checks them in order.
    class i2c_phase_scoreboard;
        logic [HOLD_W-1:0] half_period = HALF_PERIOD_RST;
        logic [HOLD_W-1:0] read_gap    = READ_GAP_RST;
        logic              sda_q = 1'b1;
        logic              drv_q = 1'b1;
        t_bus_phase        phases_due[$];
        t_bus_phase        run[$];
        int unsigned       errors = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_HALF_PERIOD)
                half_period = data;
            else if (idx == CFG_READ_GAP)
                read_gap = data;
        endfunction

        function void line(logic scl, logic sda, logic drv, logic [HOLD_W-1:0] hold);
            t_bus_phase p;
            sda_q = sda;
            drv_q = drv;
            p = '{scl: scl, sda: sda, drv: drv, hold: hold, rx: '0, ack: 1'b0, last: 1'b0};
            run.push_back(p);
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [BYTE_W-1:0] tx,
                                   logic send_ack, logic [BYTE_W-1:0] sbits,
                                   logic sack);
            logic [BYTE_W-1:0] sh;
            int                n;
            run.delete();
            case (op)
                OP_START: begin
                    line(1'b1, 1'b1, 1'b1, half_period);
                    line(1'b1, 1'b0, 1'b1, '0);
                end
                OP_STOP: begin
                    line(1'b1, 1'b0, 1'b1, half_period);
                    line(1'b1, 1'b1, 1'b1, '0);
                end
                OP_WRITE: begin
                    // drive state carries over from the previous command
                    line(1'b0, sda_q, drv_q, '0);
                    sh = tx;
                    for (int i = 0; i < 8; i++) begin
                        line(1'b1, sh[7], drv_q, half_period);
                        line(1'b0, sh[7], drv_q, half_period);
                        sh = sh << 1;
                    end
                    line(1'b0, 1'b0, 1'b1, '0);
                    line(1'b1, 1'b0, 1'b0, half_period);  // ack clock, SDA released
                    line(1'b0, 1'b0, 1'b1, '0);
                end
                default: begin
                    // read: SDA released, output latch keeps its old level
                    for (int i = 0; i < 8; i++) begin
                        line(1'b1, sda_q, 1'b0, half_period);
                        line(1'b0, sda_q, 1'b0, half_period);
                    end
                    if (send_ack)
                        line(1'b1, 1'b0, 1'b1, half_period);
                    line(1'b0, sda_q, drv_q, read_gap);
                end
            endcase
            n = run.size();
            run[n-1].last = 1'b1;
            if (op == OP_WRITE)
                run[n-1].ack = !sack;
            if (op == OP_READ)
                run[n-1].rx = sbits;
            foreach (run[i])
                phases_due.push_back(run[i]);
        endfunction

        function void cmp(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_phase(t_bus_phase got);
            t_bus_phase want;
            if (phases_due.size() == 0) begin
                $error("phase word with nothing expected: scl %0b sda %0b hold %0d",
                       got.scl, got.sda, got.hold);
                errors++;
                return;
            end
            want = phases_due.pop_front();
            cmp("scl_level", 32'(want.scl), 32'(got.scl));
            cmp("sda_level", 32'(want.sda), 32'(got.sda));
            cmp("sda_drive", 32'(want.drv), 32'(got.drv));
            cmp("hold_cycles", 32'(want.hold), 32'(got.hold));
            cmp("rx_byte", 32'(want.rx), 32'(got.rx));
            cmp("ack_ok", 32'(want.ack), 32'(got.ack));
            cmp("last_phase", 32'(want.last), 32'(got.last));
        endfunction

        function int pending();
            return phases_due.size();
        endfunction
    endclass

    // ---------------------------------------------------------------
    // Signals: every DUT input starts at a known value
    // ---------------------------------------------------------------
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [OP_W-1:0]       in_op      = OP_START;
    logic [BYTE_W-1:0]     tx_byte    = '0;
    logic                  send_ack   = 1'b0;
    logic [BYTE_W-1:0]     slave_bits = '0;
    logic                  slave_ack  = 1'b0;
    logic                  out_ready  = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    logic                  in_ready;
    logic                  out_valid;
    logic                  scl_level;
    logic                  sda_level;
    logic                  sda_drive;
    logic [HOLD_W-1:0]     hold_cycles;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  ack_ok;
    logic                  last_phase;
    logic                  cfg_ready;

    // idling odds in percent, changed between test sets
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cmds_sent      = 0;
    int unsigned quiet_cycles   = 0;

    i2c_phase_scoreboard sb;

    always #(CLK_HALF) clk = ~clk;

    i2c_master_byte_engine_unit u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_op               (in_op),
        .i_tx_byte          (tx_byte),
        .i_send_ack         (send_ack),
        .i_slave_bits       (slave_bits),
        .i_slave_sda_at_ack (slave_ack),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_scl_level        (scl_level),
        .o_sda_level        (sda_level),
        .o_sda_drive        (sda_drive),
        .o_hold_cycles      (hold_cycles),
        .o_rx_byte          (rx_byte),
        .o_ack_ok           (ack_ok),
        .o_last_phase       (last_phase),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // Receiver side: ready is drawn anew at each falling edge with the current stall odds.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor at the rising edge: check phase words first, then note new
    // commands and register writes. A command is only taken while the
    // engine is idle, so no phase word of it can share that edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_phase('{scl: scl_level, sda: sda_level, drv: sda_drive,
                                 hold: hold_cycles, rx: rx_byte, ack: ack_ok,
                                 last: last_phase});
            if (in_valid && in_ready)
                sb.note_command(in_op, tx_byte, send_ack, slave_bits, slave_ack);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end

        // watchdog: any moving word restarts the count
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offers one command; valid stays up across back-to-back words and is
    // dropped only for idle cycles or by wait_idle.
    task automatic send_command(logic [OP_W-1:0] op, logic [BYTE_W-1:0] tx,
                                logic ack_req, logic [BYTE_W-1:0] sbits,
                                logic sack);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_op      <= op;
        tx_byte    <= tx;
        send_ack   <= ack_req;
        slave_bits <= sbits;
        slave_ack  <= sack;
        do @(posedge clk); while (!in_ready);
        cmds_sent++;
    endtask

    task automatic send_random_command();
        send_command(2'($urandom_range(3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
    endtask

    // Well-formed transfer: start, address byte, one to three data bytes, stop.
    task automatic send_transfer();
        int n;
        n = $urandom_range(3, 1);
        send_command(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
        send_command(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), ($urandom_range(9) == 0));
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(1))
                send_command(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
            else  // ack all but the final byte, which gets a random ack
                send_command(OP_READ, 8'($urandom_range(255)),
                             (j < n - 1) ? 1'b1 : 1'($urandom_range(1)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        send_command(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, then wait for every expected phase word plus the
    // engine's short pipeline before touching config again.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_set(int unsigned idle_pct, int unsigned stall_pct);
        int unsigned goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = cmds_sent + RAND_PER_SET;
        while (cmds_sent < goal) begin
            // mostly complete transfers, some stray commands mixed in
            if ($urandom_range(9) < 2)
                send_random_command();
            else
                send_transfer();
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        sb = new();
        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset config: line extremes, every op, ack and nack
        send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
        send_command(OP_WRITE, 8'h00, 1'b0, 8'h00, 1'b0);
        send_command(OP_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b1);
        send_command(OP_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b0);
        send_command(OP_READ,  8'hFF, 1'b1, 8'h00, 1'b1);
        send_command(OP_READ,  8'h00, 1'b0, 8'hFF, 1'b0);
        send_command(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);
        send_command(OP_STOP,  8'hFF, 1'b1, 8'hFF, 1'b1);
        send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
        send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);  // repeated start
        send_command(OP_READ,  8'h00, 1'b1, 8'h5A, 1'b0);
        wait_idle();

        // zero half period passes through; spare indexes must be ignored
        write_cfg(CFG_HALF_PERIOD, 16'd0);
        write_cfg(CFG_READ_GAP, 16'hFFFF);
        write_cfg(CFG_SPARE_2, 16'h1234);
        write_cfg(CFG_SPARE_3, 16'hFFFF);
        send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
        send_command(OP_WRITE, 8'h3C, 1'b0, 8'h00, 1'b1);
        send_command(OP_READ,  8'h00, 1'b0, 8'hC3, 1'b0);
        // write right after an un-acked read: SDA still released on entry
        send_command(OP_WRITE, 8'h81, 1'b0, 8'h00, 1'b0);
        send_command(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);
        wait_idle();

        // random sets, one idling pattern and one config setting each
        write_cfg(CFG_HALF_PERIOD, 16'd1);
        write_cfg(CFG_READ_GAP, 16'd0);
        random_set(0, 0);

        write_cfg(CFG_HALF_PERIOD, 16'hFFFF);
        write_cfg(CFG_READ_GAP, 16'hFFFF);
        write_cfg(CFG_SPARE_2, 16'($urandom_range(65535)));
        random_set(67, 0);

        write_cfg(CFG_HALF_PERIOD, 16'($urandom_range(65535, 1)));
        write_cfg(CFG_READ_GAP, 16'($urandom_range(65535)));
        write_cfg(CFG_SPARE_3, 16'($urandom_range(65535)));
        random_set(0, 67);

        write_cfg(CFG_HALF_PERIOD, 16'd2);
        write_cfg(CFG_READ_GAP, 16'd1);
        random_set(10, 10);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_phase_gen.sv
rtl/i2c_master_byte_engine_unit.sv
rtl/i2cmbe_checker.sv
tb/testbench.sv
